### src/lcsg_pkg.sv
`default_nettype none

package lcsg_pkg;

    localparam int PHASE_BITS      = 48;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int TABLE_SIZE  = 2 ** TABLE_ADDR_BITS;
    localparam int ROM_W       = SAMPLE_BITS - 1;
    localparam int FULL_SCALE  = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int QUAD_LSB    = PHASE_BITS - 2;
    localparam int ADDR_LSB    = PHASE_BITS - 2 - TABLE_ADDR_BITS;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // configuration port
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LEN = 2'd3;

    localparam int START_INC_W = 47;
    localparam int AMP_W       = 16;
    localparam int LEN_W       = 25;
    localparam int INDEX_W     = 24;

    localparam logic [AMP_W-1:0] AMP_RESET = 16'd16384;
    localparam logic [AMP_W-1:0] AMP_FULL  = 16'd32768;
    localparam logic [LEN_W-1:0] LEN_RESET = 25'd176400;
    localparam logic [LEN_W-1:0] LEN_MAX   = 25'd16777216;

    // gain: Q1.15
    localparam int GAIN_SHIFT = 15;
    localparam int PROD_W     = ROM_W + AMP_W;

    // Quarter-wave sine entry, Taylor series through x^13 in Q30, evaluated at elaboration.
    function automatic logic [ROM_W-1:0] sine_entry(input int i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        x    = (64'(2 * i + 1) * HALF_PI_Q30) >> (TABLE_ADDR_BITS + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        e = (sum * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
        if (e > 64'(FULL_SCALE))
        begin
            e = 64'(FULL_SCALE);
        end
        return e[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/lcsg_sine_rom.sv
`default_nettype none

module lcsg_sine_rom (
    input  wire logic                                   clk,
    input  wire logic                                   en,
    input  wire logic [lcsg_pkg::TABLE_ADDR_BITS-1:0]   addr,
    output logic      [lcsg_pkg::ROM_W-1:0]             data
);

    logic [lcsg_pkg::ROM_W-1:0] sine_tbl [lcsg_pkg::TABLE_SIZE];

    for (genvar g = 0; g < lcsg_pkg::TABLE_SIZE; g++)
    begin : g_table
        assign sine_tbl[g] = lcsg_pkg::sine_entry(g);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data <= sine_tbl[addr];
        end
    end

endmodule

`default_nettype wire

### src/linear_chirp_sine_generator.sv
`default_nettype none

// Linear chirp sine generator.
// Input channel (in_valid/in_ready, restart): each transfer is one sample tick.
// restart=1 makes that tick sample zero of a new sweep. Output channel
// (out_valid/out_ready, sample, last) carries one sample per tick; last marks
// the final sample of a sweep, after which the sweep starts over on its own.
// Throughput is one sample per cycle while the receiver does not stall:
// phase, increment and sample index update at each input transfer. Latency
// is three stages: the sine ROM read register, the gain product register
// and the output register.
// When the receiver stalls the whole pipeline holds and in_ready drops; the
// output register keeps its sample until taken.
// The configuration port (cfg_write, cfg_index, cfg_data) writes start
// increment, sweep step, amplitude and sweep length; write only while idle.
// A new start increment is used at the next restart or sweep end.
// Reset clears phase, increment and index, empties the pipeline and loads the
// default amplitude (half scale) and sweep length (176400).
module linear_chirp_sine_generator (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [lcsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lcsg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 restart,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [lcsg_pkg::SAMPLE_BITS-1:0]   sample,
    output logic                                      last
);

    // configuration
    logic [lcsg_pkg::START_INC_W-1:0] start_inc_reg;
    logic [lcsg_pkg::PHASE_BITS-1:0]  sweep_step_reg;
    logic [lcsg_pkg::AMP_W-1:0]       amp_reg;
    logic [lcsg_pkg::LEN_W-1:0]       len_reg;

    // sweep state
    logic [lcsg_pkg::PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [lcsg_pkg::PHASE_BITS-1:0]  inc_reg, inc_next;
    logic [lcsg_pkg::INDEX_W-1:0]     idx_reg, idx_next;

    logic [lcsg_pkg::PHASE_BITS-1:0]  cur_phase;
    logic [lcsg_pkg::PHASE_BITS-1:0]  cur_inc;
    logic [lcsg_pkg::INDEX_W-1:0]     cur_idx;
    logic [lcsg_pkg::LEN_W-1:0]       len_eff;
    logic                             cur_last;
    logic [1:0]                       cur_quad;
    logic [lcsg_pkg::TABLE_ADDR_BITS-1:0] cur_addr;
    logic [lcsg_pkg::AMP_W-1:0]       cur_amp;

    logic adv;
    logic in_fire;

    // pipeline
    logic                              s1_valid_reg;
    logic                              s1_neg_reg;
    logic                              s1_last_reg;
    logic [lcsg_pkg::AMP_W-1:0]        s1_amp_reg;
    logic [lcsg_pkg::ROM_W-1:0]        rom_data;

    logic                              s2_valid_reg;
    logic                              s2_neg_reg;
    logic                              s2_last_reg;
    logic [lcsg_pkg::PROD_W-1:0]       s2_prod_reg;

    logic [lcsg_pkg::PROD_W:0]         rounded;
    logic [lcsg_pkg::PROD_W-lcsg_pkg::GAIN_SHIFT:0] mag;
    logic [lcsg_pkg::SAMPLE_BITS-1:0]  mag_sat;
    logic [lcsg_pkg::SAMPLE_BITS-1:0]  sample_next;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_inc_reg  <= '0;
            sweep_step_reg <= '0;
            amp_reg        <= lcsg_pkg::AMP_RESET;
            len_reg        <= lcsg_pkg::LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lcsg_pkg::REG_START_INC:
                    start_inc_reg <= cfg_data[lcsg_pkg::START_INC_W-1:0];
                lcsg_pkg::REG_SWEEP_STEP:
                    sweep_step_reg <= cfg_data[lcsg_pkg::PHASE_BITS-1:0];
                lcsg_pkg::REG_AMPLITUDE:
                    amp_reg <= cfg_data[lcsg_pkg::AMP_W-1:0];
                lcsg_pkg::REG_SWEEP_LEN:
                    len_reg <= cfg_data[lcsg_pkg::LEN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        cur_phase = restart ? '0 : phase_reg;
        cur_inc   = restart ? lcsg_pkg::PHASE_BITS'(start_inc_reg) : inc_reg;
        cur_idx   = restart ? '0 : idx_reg;

        if (len_reg == '0)
        begin
            len_eff = lcsg_pkg::LEN_W'(1);
        end
        else if (len_reg > lcsg_pkg::LEN_MAX)
        begin
            len_eff = lcsg_pkg::LEN_MAX;
        end
        else
        begin
            len_eff = len_reg;
        end

        cur_last = (lcsg_pkg::LEN_W'(cur_idx) + lcsg_pkg::LEN_W'(1)) >= len_eff;

        cur_quad = cur_phase[lcsg_pkg::QUAD_LSB +: 2];
        cur_addr = cur_phase[lcsg_pkg::ADDR_LSB +: lcsg_pkg::TABLE_ADDR_BITS];
        if (cur_quad[0])
        begin
            cur_addr = ~cur_addr;   // mirrored quadrant
        end

        cur_amp = (amp_reg > lcsg_pkg::AMP_FULL) ? lcsg_pkg::AMP_FULL : amp_reg;

        if (cur_last)
        begin
            phase_next = '0;
            inc_next   = lcsg_pkg::PHASE_BITS'(start_inc_reg);
            idx_next   = '0;
        end
        else
        begin
            phase_next = cur_phase + cur_inc;
            inc_next   = cur_inc + sweep_step_reg;
            idx_next   = cur_idx + lcsg_pkg::INDEX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            inc_reg   <= '0;
            idx_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            inc_reg   <= inc_next;
            idx_reg   <= idx_next;
        end
    end

    lcsg_sine_rom u_rom (
        .clk  (clk),
        .en   (adv),
        .addr (cur_addr),
        .data (rom_data)
    );

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            out_valid    <= s2_valid_reg;
        end
    end

    // gain rounding: half away from zero on the magnitude
    always_comb
    begin
        rounded = (lcsg_pkg::PROD_W + 1)'(s2_prod_reg)
                + (lcsg_pkg::PROD_W + 1)'(1 << (lcsg_pkg::GAIN_SHIFT - 1));
        mag     = rounded[lcsg_pkg::PROD_W:lcsg_pkg::GAIN_SHIFT];
        if (mag > ($bits(mag))'(lcsg_pkg::FULL_SCALE))
        begin
            mag_sat = lcsg_pkg::SAMPLE_BITS'(lcsg_pkg::FULL_SCALE);
        end
        else
        begin
            mag_sat = mag[lcsg_pkg::SAMPLE_BITS-1:0];
        end
        sample_next = s2_neg_reg ? (~mag_sat + lcsg_pkg::SAMPLE_BITS'(1)) : mag_sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_neg_reg  <= cur_quad[1];
            s1_last_reg <= cur_last;
            s1_amp_reg  <= cur_amp;

            s2_neg_reg  <= s1_neg_reg;
            s2_last_reg <= s1_last_reg;
            s2_prod_reg <= lcsg_pkg::PROD_W'(rom_data) * lcsg_pkg::PROD_W'(s1_amp_reg);

            sample      <= sample_next;
            last        <= s2_last_reg;
        end
    end

    // after a final sample the sweep state is back at its start
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && cur_last |=> idx_reg == '0 && phase_reg == '0)
        else $error("sweep state not cleared after last sample");

    // a result only appears from the product stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s2_valid_reg))
        else $error("output valid without a product in flight");

    // magnitude is clamped, so the most negative code never occurs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != {1'b1, {(lcsg_pkg::SAMPLE_BITS-1){1'b0}}})
        else $error("sample below negative full scale");

    // the index never runs past the longest sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !restart |-> lcsg_pkg::LEN_W'(idx_reg) < lcsg_pkg::LEN_MAX)
        else $error("sample index out of range");

endmodule

`default_nettype wire
